@@ design/psis_pkg.sv @@
// ----------------------------------------------------------------------------
// psis_pkg
// Shared widths, opcodes and types for the prefix-sum index search block.
// ----------------------------------------------------------------------------
package psis_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int VALUE_W     = 27;
   localparam int INDEX_W     = 11;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESULT
   } state_type;

   // finished query handed from the controller to the response register
   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] index;
   } result_type;

endpackage

@@ design/psis_if.sv @@
// ----------------------------------------------------------------------------
// psis_req_if / psis_rsp_if
// Valid/ready channels for requests and responses of the index search block.
// ----------------------------------------------------------------------------
interface psis_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [psis_pkg::VALUE_W-1:0]  item_value;

   modport source (output valid, output opcode, output item_value, input ready);
   modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface psis_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psis_pkg::INDEX_W-1:0]  bucket_index;

   modport source (output valid, output bucket_index, input ready);
   modport sink   (input valid, input bucket_index, output ready);
endinterface

@@ design/psis_ram.sv @@
// ----------------------------------------------------------------------------
// psis_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module psis_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 27
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ design/psis_ctrl.sv @@
// ----------------------------------------------------------------------------
// psis_ctrl
// Append and lower-bound search sequencer around the prefix-sum RAM.
// ----------------------------------------------------------------------------
module psis_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   psis_req_if.sink                       req_chan,
   input  logic                           res_take,
   output psis_pkg::result_type           res,
   output logic                           ram_wr_en,
   output logic [psis_pkg::ADDR_W-1:0]    ram_wr_addr,
   output logic [psis_pkg::VALUE_W-1:0]   ram_wr_data,
   output logic                           ram_rd_en,
   output logic [psis_pkg::ADDR_W-1:0]    ram_rd_addr,
   input  logic [psis_pkg::VALUE_W-1:0]   ram_rd_data
);

   localparam int CW = psis_pkg::COUNT_W;
   localparam int VW = psis_pkg::VALUE_W;

   psis_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [VW-1:0] total_ff, total_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [VW-1:0] pos_ff, pos_in;

   logic          accept;
   logic [VW:0]   sum;
   logic [CW-1:0] lo_nxt;
   logic [CW-1:0] hi_nxt;
   logic [CW-1:0] mid_nxt;

   function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo,
                                            input logic [CW-1:0] hi);
      logic [CW-1:0] span;
      span   = hi - lo;
      mid_of = lo + (span >> 1);
   endfunction

   assign req_chan.ready = (state_ff == psis_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // saturating running total
   assign sum = {1'b0, total_ff} + {1'b0, req_chan.item_value};

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      pos_in      = pos_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[psis_pkg::ADDR_W-1:0];
      ram_wr_data = sum[VW] ? {VW{1'b1}} : sum[VW-1:0];
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      res.valid   = 1'b0;
      res.index   = psis_pkg::INDEX_W'(hi_ff);
      lo_nxt      = lo_ff;
      hi_nxt      = hi_ff;
      mid_nxt     = mid_ff;

      case (state_ff)
         psis_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_chan.opcode == psis_pkg::OP_APPEND) begin
                  // a full store drops the append
                  if (count_ff != CW'(psis_pkg::MAX_ENTRIES)) begin
                     ram_wr_en = 1'b1;
                     total_in  = ram_wr_data;
                     count_in  = count_ff + CW'(1);
                  end
               end else begin
                  pos_in  = req_chan.item_value;
                  lo_in   = CW'(1);
                  hi_in   = count_ff;
                  mid_nxt = mid_of(CW'(1), count_ff);
                  mid_in  = mid_nxt;
                  if (count_ff > CW'(1)) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = psis_pkg::ADDR_W'(mid_nxt - CW'(1));
                     state_in    = psis_pkg::ST_SEARCH;
                  end else begin
                     state_in = psis_pkg::ST_RESULT;
                  end
               end
            end
         end
         psis_pkg::ST_SEARCH: begin
            // RAM data belongs to mid_ff; narrow the range, then fetch the next probe or finish
            if (ram_rd_data < pos_ff) begin
               lo_nxt = mid_ff + CW'(1);
            end else begin
               hi_nxt = mid_ff;
            end
            lo_in   = lo_nxt;
            hi_in   = hi_nxt;
            mid_nxt = mid_of(lo_nxt, hi_nxt);
            mid_in  = mid_nxt;
            if (hi_nxt > lo_nxt) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = psis_pkg::ADDR_W'(mid_nxt - CW'(1));
            end else begin
               state_in = psis_pkg::ST_RESULT;
            end
         end
         psis_pkg::ST_RESULT: begin
            res.valid = 1'b1;
            if (res_take) begin
               state_in = psis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psis_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psis_pkg::ST_IDLE;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      pos_ff <= pos_in;
   end

endmodule

@@ design/prefix_sum_index_search.sv @@
// ----------------------------------------------------------------------------
// prefix_sum_index_search
// Running prefix-sum store with a lower-bound index search on query.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan (valid/ready). Opcode append adds item_value to
// a saturating running total and stores the new sum as the next entry; it
// gives no response and is dropped silently once the store is full. Opcode
// query searches the stored sums for the first entry at or above item_value
// and returns its 1-based index on rsp_chan, the last index when none
// reaches it, 0 with an empty store.
// A query makes one RAM read per halving step, with the compare feeding the
// next read address in the same cycle; the prefix-sum RAM has a single read
// port. Requests are taken one at a time; a query's search runs while an
// earlier response still waits in the output register, and the controller
// holds a finished result until that register frees up, so a stalled
// receiver backs up into req_chan.ready.
// Synchronous reset empties the store (count and total to zero) at once; no
// clearing pass, as entries beyond the count are never read.
// ----------------------------------------------------------------------------
module prefix_sum_index_search (
   input  logic        clock,
   input  logic        reset,
   psis_req_if.sink    req_chan,
   psis_rsp_if.source  rsp_chan
);

   psis_pkg::result_type res;
   logic                 res_take;

   logic                            ram_wr_en;
   logic [psis_pkg::ADDR_W-1:0]     ram_wr_addr;
   logic [psis_pkg::VALUE_W-1:0]    ram_wr_data;
   logic                            ram_rd_en;
   logic [psis_pkg::ADDR_W-1:0]     ram_rd_addr;
   logic [psis_pkg::VALUE_W-1:0]    ram_rd_data;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [psis_pkg::INDEX_W-1:0]    rsp_index_ff, rsp_index_in;

   psis_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .res_take    (res_take),
      .res         (res),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   psis_ram #(
      .DEPTH (psis_pkg::MAX_ENTRIES),
      .WIDTH (psis_pkg::VALUE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register: load when empty or being emptied this cycle
   assign res_take = res.valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = res.index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.bucket_index = rsp_index_ff;

endmodule

@@ sim/prefix_sum_index_search_tb.sv @@
// ----------------------------------------------------------------------------
// prefix_sum_index_search_tb
// Self-checking bench for the prefix-sum index search block. A short table of
// directed transactions covers the empty store, tied sums, positions past the
// total and the extremes of the value field. Random appends and queries
// follow. They fill the store, saturate the running total and push appends
// at a full store. Each query response is checked against a local lower-bound
// predictor or a typed directed index; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module prefix_sum_index_search_tb;

   localparam int MAX_ENTRIES   = psis_pkg::MAX_ENTRIES;
   localparam int ADDR_W        = psis_pkg::ADDR_W;
   localparam int COUNT_W       = psis_pkg::COUNT_W;
   localparam int VALUE_W       = psis_pkg::VALUE_W;
   localparam int INDEX_W       = psis_pkg::INDEX_W;

   localparam int NUM_DIRECTED  = 18;
   localparam int TOTAL_ITEMS   = 1850;
   localparam int IDLE_LIMIT    = 4000;
   localparam int TAIL_CYCLES   = 40;
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   typedef struct packed {
      logic               op;
      logic [VALUE_W-1:0] value;
      logic               known;
      logic [INDEX_W-1:0] index;
   } stim_row_type;

   // index typed in only where it is plain from the stored sums so far
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{psis_pkg::OP_QUERY,  27'd0,         1'b1, 11'd0},  // empty store
      '{psis_pkg::OP_QUERY,  VALUE_MAX,     1'b1, 11'd0},  // empty store, top position
      '{psis_pkg::OP_APPEND, 27'd0,         1'b0, 11'd0},
      '{psis_pkg::OP_APPEND, 27'd0,         1'b0, 11'd0},
      '{psis_pkg::OP_QUERY,  27'd0,         1'b1, 11'd1},  // tie, lowest index wins
      '{psis_pkg::OP_QUERY,  27'd1,         1'b1, 11'd2},  // past the total
      '{psis_pkg::OP_APPEND, 27'd65535,     1'b0, 11'd0},
      '{psis_pkg::OP_QUERY,  27'd65535,     1'b0, 11'd0},
      '{psis_pkg::OP_QUERY,  27'd65534,     1'b0, 11'd0},
      '{psis_pkg::OP_QUERY,  27'd65536,     1'b1, 11'd3},  // past the total
      '{psis_pkg::OP_APPEND, 27'd1,         1'b0, 11'd0},
      '{psis_pkg::OP_QUERY,  27'd65536,     1'b0, 11'd0},
      '{psis_pkg::OP_QUERY,  27'd1,         1'b0, 11'd0},
      '{psis_pkg::OP_APPEND, 27'd0,         1'b0, 11'd0},
      '{psis_pkg::OP_QUERY,  27'd65536,     1'b1, 11'd4},  // tie at the end
      '{psis_pkg::OP_QUERY,  VALUE_MAX,     1'b1, 11'd5},
      '{psis_pkg::OP_APPEND, 27'h4000000,   1'b0, 11'd0},
      '{psis_pkg::OP_QUERY,  27'h4000000,   1'b0, 11'd0}
   };

   logic clock;
   logic reset;

   psis_req_if req_chan_if ();
   psis_rsp_if rsp_chan_if ();

   prefix_sum_index_search u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan_if.sink),
      .rsp_chan (rsp_chan_if.source)
   );

   // predictor state
   logic [VALUE_W-1:0]  stored_sums [MAX_ENTRIES];
   logic [COUNT_W-1:0]  stored_count;
   logic [VALUE_W-1:0]  stored_total;
   logic [INDEX_W-1:0]  expected_index_q [$];

   // stimulus-side view of the store, kept by the sender
   int                  plan_count;
   logic [VALUE_W-1:0]  plan_total;

   int  fail_count;
   int  accepted_items;
   int  idle_cycles;
   bit  steady_run;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [INDEX_W-1:0] find_first_reaching(input logic [VALUE_W-1:0] pos);
      for (int k = 0; k < int'(stored_count); k++) begin
         if (stored_sums[k] >= pos) return INDEX_W'(k + 1);
      end
      return INDEX_W'(stored_count);
   endfunction

   task automatic store_bucket(input logic [VALUE_W-1:0] size);
      logic [VALUE_W:0] sum;
      if (int'(stored_count) < MAX_ENTRIES) begin
         sum = {1'b0, stored_total} + {1'b0, size};
         stored_total = sum[VALUE_W] ? VALUE_MAX : sum[VALUE_W-1:0];
         stored_sums[stored_count[ADDR_W-1:0]] = stored_total;
         stored_count = stored_count + 1'b1;
      end
   endtask

   // request and response monitor; request first so a queue push is seen
   always @(posedge clock) begin
      logic [INDEX_W-1:0] predicted;
      if (!reset) begin
         if (req_chan_if.valid && req_chan_if.ready) begin
            if (req_chan_if.opcode == psis_pkg::OP_APPEND) begin
               store_bucket(req_chan_if.item_value);
            end else begin
               predicted = find_first_reaching(req_chan_if.item_value);
               if (accepted_items < NUM_DIRECTED && directed_rows[accepted_items].known)
                  predicted = directed_rows[accepted_items].index;
               expected_index_q.insert(expected_index_q.size(), predicted);
            end
            accepted_items++;
         end
         if (rsp_chan_if.valid && rsp_chan_if.ready) begin
            if (expected_index_q.size() == 0) begin
               $error("bucket_index: no response expected, actual %0d",
                      rsp_chan_if.bucket_index);
               fail_count++;
            end else begin
               predicted = expected_index_q.pop_front();
               if (rsp_chan_if.bucket_index !== predicted) begin
                  $error("bucket_index mismatch: expected %0d, actual %0d",
                         predicted, rsp_chan_if.bucket_index);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_chan_if.valid && req_chan_if.ready) ||
          (rsp_chan_if.valid && rsp_chan_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_run || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver: ready high for a while, then a stall of random length
   initial begin
      int off_cycles;
      rsp_chan_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_chan_if.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         off_cycles = pick_gap();
         if (off_cycles > 0) begin
            rsp_chan_if.ready <= 1'b0;
            repeat (off_cycles) @(posedge clock);
         end
      end
   end

   task automatic push_item(input logic op, input logic [VALUE_W-1:0] val);
      logic [VALUE_W:0] sum;
      req_chan_if.valid      <= 1'b1;
      req_chan_if.opcode     <= op;
      req_chan_if.item_value <= val;
      @(posedge clock);
      while (!req_chan_if.ready) @(posedge clock);
      if (op == psis_pkg::OP_APPEND && plan_count < MAX_ENTRIES) begin
         sum        = {1'b0, plan_total} + {1'b0, val};
         plan_total = sum[VALUE_W] ? VALUE_MAX : sum[VALUE_W-1:0];
         plan_count++;
      end
   endtask

   task automatic hold_sender(input int cycles);
      if (cycles > 0) begin
         req_chan_if.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // the edge first lets the monitor record the last transaction
   task automatic drain_responses();
      req_chan_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_index_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_bucket_size();
      int roll;
      roll = $urandom_range(0, 99);
      // wide sizes only near the end, so the total saturates late
      if (plan_count >= 1000 && roll < 25) return VALUE_W'($urandom);
      if (roll < 10) return '0;
      if (roll < 18) return VALUE_W'($urandom_range(0, 3));
      return VALUE_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [VALUE_W-1:0] pick_position();
      int roll;
      int k;
      logic [VALUE_W:0] upper;
      roll = $urandom_range(0, 99);
      upper = {1'b0, plan_total} + (VALUE_W + 1)'(2000);
      if (upper[VALUE_W]) upper = {1'b0, VALUE_MAX};
      if (roll < 30) return VALUE_W'($urandom_range(0, int'(plan_total)));
      if (roll < 45 && plan_count >= 2) begin
         // land on or just past a sum that is long since stored
         k = $urandom_range(0, plan_count - 2);
         return stored_sums[k] + VALUE_W'($urandom_range(0, 1));
      end
      if (roll < 55) return '0;
      if (roll < 65) return (plan_total == VALUE_MAX) ? plan_total
                                                      : plan_total + VALUE_W'($urandom_range(0, 1));
      if (roll < 80) return VALUE_W'($urandom);
      return VALUE_W'($urandom_range(0, int'(upper)));
   endfunction

   initial begin
      fail_count     = 0;
      accepted_items = 0;
      idle_cycles    = 0;
      steady_run     = 1'b0;
      plan_count     = 0;
      plan_total     = '0;
      stored_count   = '0;
      stored_total   = '0;
      reset                  <= 1'b1;
      req_chan_if.valid      <= 1'b0;
      req_chan_if.opcode     <= psis_pkg::OP_APPEND;
      req_chan_if.item_value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         push_item(directed_rows[i].op, directed_rows[i].value);
         hold_sender(pick_gap());
      end
      drain_responses();

      for (int n = NUM_DIRECTED; n < TOTAL_ITEMS; n++) begin
         steady_run = (n >= 600 && n < 700) || (n >= 1400 && n < 1460);
         if (n % 300 == 0) drain_responses();
         if ($urandom_range(0, 99) < 58)
            push_item(psis_pkg::OP_APPEND, pick_bucket_size());
         else
            push_item(psis_pkg::OP_QUERY, pick_position());
         hold_sender(pick_gap());
      end
      steady_run = 1'b0;

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_index_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
